### design/rgb_channel_histogram_defines.svh
// Assertion macros for the RGB histogram block.
`ifndef RGB_CHANNEL_HISTOGRAM_DEFINES_SVH
`define RGB_CHANNEL_HISTOGRAM_DEFINES_SVH
`ifndef SYNTHESIS
`define RGBH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RGBH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RGBH_ASSERT(label, prop, msg)
`define RGBH_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### design/rgbh_pkg.sv
package rgbh_pkg;
  localparam int BIN_COUNT  = 256;
  localparam int COUNT_BITS = 24;
  localparam int IDX_W      = $clog2(BIN_COUNT);
  localparam int LVL_W      = 8;
  localparam int VIEW_W     = 12;
  localparam int CNT_FLD_W  = 24;
  localparam int BAR_W      = 11;
  localparam int NUM_CH     = 3;
  localparam int DVD_W      = COUNT_BITS + VIEW_W;
  localparam int DVS_W      = COUNT_BITS + 1;
  localparam logic [VIEW_W-1:0] VIEW_RESET = VIEW_W'(256);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ACCUM = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Map a level or bin index onto the last bin when it lies beyond the table
  function automatic logic [IDX_W-1:0] clamp_bin(input logic [LVL_W-1:0] v);
    logic [LVL_W:0] wide;
    wide = {1'b0, v};
    if (wide >= (LVL_W+1)'(BIN_COUNT)) begin
      return IDX_W'(BIN_COUNT - 1);
    end
    return v[IDX_W-1:0];
  endfunction
endpackage

### design/rgbh_bin_mem.sv
module rgbh_bin_mem (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [rgbh_pkg::IDX_W-1:0]     addr_i,
  input  logic [rgbh_pkg::COUNT_BITS-1:0] wdata_i,
  output logic [rgbh_pkg::COUNT_BITS-1:0] rdata_o
);
  import rgbh_pkg::*;

  logic [COUNT_BITS-1:0] mem_q [BIN_COUNT];
  logic [COUNT_BITS-1:0] rdata_q;

  // Write one bin, register the read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### design/rgbh_div.sv
module rgbh_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rgbh_pkg::DVD_W-1:0]  dividend_i,
  input  logic [rgbh_pkg::DVS_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [rgbh_pkg::DVD_W-1:0]  quotient_o
);
  import rgbh_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;

  // One quotient bit per cycle, restoring form
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[DVD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DVS_W-1:0];
        quo_d = {quo_q[DVD_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

### design/rgb_channel_histogram.sv
// RGB channel histogram: three 256-bin pixel histograms with bar scaling.
// Input channel in_valid_i / in_stall_o carries one command item: clear,
// accumulate pixel (red/green/blue levels) or read bin (bin_index). Code 3
// is taken and ignored. Only read returns an item on out_valid_o /
// out_stall_i: the three bin counts with bar heights and bar tops.
// The user must write view_height via cfg_we_i / cfg_wdata_i only while
// idle; the block does not enforce this. Accumulate reads the bin, then
// writes it back, through the single port of each bin memory. Clear walks
// all 256 bins, one bin per cycle. Read runs six scalings one after
// another through one multiplier and one bit-serial divider. After reset
// the block walks all bins to zero with in_stall_o high. A finished read
// item stays on the outputs while out_stall_i is high, and no new item is
// taken until it leaves.
module rgb_channel_histogram
  import rgbh_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rgbh_pkg::VIEW_W-1:0]      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       command_i,
  input  logic [rgbh_pkg::LVL_W-1:0]       red_level_i,
  input  logic [rgbh_pkg::LVL_W-1:0]       green_level_i,
  input  logic [rgbh_pkg::LVL_W-1:0]       blue_level_i,
  input  logic [rgbh_pkg::LVL_W-1:0]       bin_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [rgbh_pkg::CNT_FLD_W-1:0]   red_count_o,
  output logic [rgbh_pkg::CNT_FLD_W-1:0]   green_count_o,
  output logic [rgbh_pkg::CNT_FLD_W-1:0]   blue_count_o,
  output logic [rgbh_pkg::BAR_W-1:0]       red_height_o,
  output logic [rgbh_pkg::BAR_W-1:0]       green_height_o,
  output logic [rgbh_pkg::BAR_W-1:0]       blue_height_o,
  output logic [rgbh_pkg::BAR_W-1:0]       red_top_o,
  output logic [rgbh_pkg::BAR_W-1:0]       green_top_o,
  output logic [rgbh_pkg::BAR_W-1:0]       blue_top_o
);
`include "rgb_channel_histogram_defines.svh"

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_LATCH = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_START = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam int NUM_JOBS = 2 * NUM_CH;
  localparam int JOB_W    = $clog2(NUM_JOBS);
  localparam int CH_W     = $clog2(NUM_CH);

  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      clr_q, clr_d;
  logic [JOB_W-1:0]      job_q, job_d;
  logic [VIEW_W-1:0]     view_q;
  logic [COUNT_BITS-1:0] peak_q [NUM_CH];
  logic [COUNT_BITS-1:0] cnt_q [NUM_CH];
  logic [COUNT_BITS-1:0] rest_q [NUM_CH];
  logic [BAR_W-1:0]      res_q [NUM_JOBS];
  logic [IDX_W-1:0]      addr_q [NUM_CH];
  logic [DVD_W-1:0]      prod_q;

  logic                  in_acc;
  logic [LVL_W-1:0]      lvl [NUM_CH];
  logic [IDX_W-1:0]      mem_addr [NUM_CH];
  logic                  mem_we;
  logic [COUNT_BITS-1:0] mem_wdata [NUM_CH];
  logic [COUNT_BITS-1:0] mem_rdata [NUM_CH];
  logic [COUNT_BITS-1:0] inc [NUM_CH];
  logic [CH_W-1:0]       job_ch;
  logic                  job_top;
  logic [COUNT_BITS-1:0] num_sel;
  logic [COUNT_BITS-1:0] peak_sel;
  logic                  div_start;
  logic                  div_busy;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quo;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign lvl[0]     = red_level_i;
  assign lvl[1]     = green_level_i;
  assign lvl[2]     = blue_level_i;

  // Pick the scaling job operands: counts first, then tops
  assign job_top  = (job_q >= JOB_W'(NUM_CH));
  assign job_ch   = job_top ? CH_W'(job_q - JOB_W'(NUM_CH)) : CH_W'(job_q);
  assign num_sel  = job_top ? rest_q[job_ch] : cnt_q[job_ch];
  assign peak_sel = peak_q[job_ch];
  assign mem_we   = (state_q == S_CLEAR) || (state_q == S_ACC);
  assign div_start = (state_q == S_START);

  // Bin memories, one per channel
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    always_comb begin
      case (state_q)
        S_IDLE:  mem_addr[c] = (command_i == CMD_READ) ? clamp_bin(bin_index_i)
                                                       : clamp_bin(lvl[c]);
        S_CLEAR: mem_addr[c] = clr_q;
        default: mem_addr[c] = addr_q[c];
      endcase
    end
    assign inc[c] = (mem_rdata[c] == COUNT_MAX) ? mem_rdata[c]
                                                 : mem_rdata[c] + COUNT_BITS'(1);
    assign mem_wdata[c] = (state_q == S_CLEAR) ? '0 : inc[c];

    rgbh_bin_mem u_mem (
      .clk_i   (clk_i),
      .we_i    (mem_we),
      .addr_i  (mem_addr[c]),
      .wdata_i (mem_wdata[c]),
      .rdata_o (mem_rdata[c])
    );
  end

  rgbh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  ({peak_sel, 1'b0}),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    job_d   = job_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(BIN_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (command_i)
            CMD_CLEAR: begin
              state_d = S_CLEAR;
              clr_d   = '0;
            end
            CMD_ACCUM: state_d = S_ACC;
            CMD_READ:  state_d = S_LATCH;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_ACC:   state_d = S_IDLE;
      S_LATCH: begin
        state_d = S_MUL;
        job_d   = '0;
      end
      S_MUL: begin
        if (peak_sel == '0) begin
          if (job_q == JOB_W'(NUM_JOBS - 1)) begin
            state_d = S_OUT;
          end else begin
            job_d = job_q + JOB_W'(1);
          end
        end else begin
          state_d = S_START;
        end
      end
      S_START: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          if (job_q == JOB_W'(NUM_JOBS - 1)) begin
            state_d = S_OUT;
          end else begin
            job_d   = job_q + JOB_W'(1);
            state_d = S_MUL;
          end
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      job_q   <= '0;
      view_q  <= VIEW_RESET;
      for (int c = 0; c < NUM_CH; c++) begin
        peak_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      job_q   <= job_d;
      if (cfg_we_i) begin
        view_q <= cfg_wdata_i;
      end
      // Drop peaks on clear, raise them on accumulate
      for (int c = 0; c < NUM_CH; c++) begin
        if (state_q == S_IDLE && in_acc && command_i == CMD_CLEAR) begin
          peak_q[c] <= '0;
        end else if (state_q == S_ACC && inc[c] > peak_q[c]) begin
          peak_q[c] <= inc[c];
        end
      end
    end
  end

  // Operand and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      for (int c = 0; c < NUM_CH; c++) begin
        addr_q[c] <= mem_addr[c];
      end
    end
    if (state_q == S_LATCH) begin
      for (int c = 0; c < NUM_CH; c++) begin
        cnt_q[c]  <= mem_rdata[c];
        rest_q[c] <= (peak_q[c] >= mem_rdata[c]) ? peak_q[c] - mem_rdata[c] : '0;
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= num_sel * view_q;
      if (peak_sel == '0) begin
        res_q[job_q] <= '0;
      end
    end
    if (state_q == S_DIV && div_done) begin
      res_q[job_q] <= div_quo[BAR_W-1:0];
    end
  end

  assign out_valid_o    = (state_q == S_OUT);
  assign red_count_o    = CNT_FLD_W'(cnt_q[0]);
  assign green_count_o  = CNT_FLD_W'(cnt_q[1]);
  assign blue_count_o   = CNT_FLD_W'(cnt_q[2]);
  assign red_height_o   = res_q[0];
  assign green_height_o = res_q[1];
  assign blue_height_o  = res_q[2];
  assign red_top_o      = res_q[3];
  assign green_top_o    = res_q[4];
  assign blue_top_o     = res_q[5];

  `RGBH_ASSERT(a_out_blocks_in, out_valid_o |-> in_stall_o, "input taken while result pending")
  `RGBH_ASSERT(a_read_stalls, in_acc && command_i == CMD_READ |=> in_stall_o && !out_valid_o,
               "read returned without scaling")
  `RGBH_ASSERT(a_div_in_div, div_busy |-> state_q == S_DIV, "divider running outside divide")
  `RGBH_ASSERT_ALWAYS(a_reset_clear, !rst_ni |-> in_stall_o, "input taken during reset")
endmodule

### test/rgb_channel_histogram_tb.sv
`default_nettype none

module rgb_channel_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rgbh_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int PHASE_ITEMS = 126;

  typedef struct packed {
    logic [CNT_FLD_W-1:0] rc, gc, bc;
    logic [BAR_W-1:0]     rh, gh, bh, rt, gt, bt;
  } bar_readout_t;

  typedef struct {
    logic [1:0]       cmd;
    logic [LVL_W-1:0] r, g, b, idx;
    bit               typed;
    bar_readout_t     readout;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [VIEW_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = CMD_CLEAR;
  logic [LVL_W-1:0] red_level_i = '0, green_level_i = '0, blue_level_i = '0;
  logic [LVL_W-1:0] bin_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [CNT_FLD_W-1:0] red_count_o, green_count_o, blue_count_o;
  logic [BAR_W-1:0] red_height_o, green_height_o, blue_height_o;
  logic [BAR_W-1:0] red_top_o, green_top_o, blue_top_o;

  // Histogram mirror
  logic [COUNT_BITS-1:0] hist_bins [NUM_CH][BIN_COUNT];
  logic [COUNT_BITS-1:0] hist_peak [NUM_CH];
  logic [VIEW_W-1:0]     view_height;
  bar_readout_t          readouts_pending[$];
  logic [LVL_W-1:0]      hot_level [8];

  int  mismatches = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  long_hold_go = 1'b0;

  rgb_channel_histogram u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .command_i, .red_level_i, .green_level_i, .blue_level_i, .bin_index_i,
    .out_valid_o, .out_stall_i, .red_count_o, .green_count_o, .blue_count_o,
    .red_height_o, .green_height_o, .blue_height_o,
    .red_top_o, .green_top_o, .blue_top_o
  );

  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [BAR_W-1:0] bar_scale(logic [COUNT_BITS-1:0] num,
                                                 logic [COUNT_BITS-1:0] peak);
    longint unsigned q;
    if (peak == 0) return '0;
    q = (longint'(num) * longint'(view_height)) / (2 * longint'(peak));
    return q[BAR_W-1:0];
  endfunction

  function automatic void clear_histogram();
    for (int c = 0; c < NUM_CH; c++) begin
      for (int i = 0; i < BIN_COUNT; i++) hist_bins[c][i] = '0;
      hist_peak[c] = '0;
    end
  endfunction

  function automatic void count_pixel(logic [LVL_W-1:0] r, logic [LVL_W-1:0] g,
                                      logic [LVL_W-1:0] b);
    logic [LVL_W-1:0] lvl [NUM_CH];
    lvl = '{r, g, b};
    for (int c = 0; c < NUM_CH; c++) begin
      if (hist_bins[c][lvl[c]] != COUNT_MAX) hist_bins[c][lvl[c]]++;
      if (hist_bins[c][lvl[c]] > hist_peak[c]) hist_peak[c] = hist_bins[c][lvl[c]];
    end
  endfunction

  function automatic bar_readout_t predict_readout(logic [LVL_W-1:0] idx);
    bar_readout_t o;
    logic [COUNT_BITS-1:0] cnt [NUM_CH];
    logic [COUNT_BITS-1:0] rest [NUM_CH];
    logic [BAR_W-1:0] hgt [NUM_CH];
    logic [BAR_W-1:0] top [NUM_CH];
    for (int c = 0; c < NUM_CH; c++) begin
      cnt[c] = hist_bins[c][idx];
      rest[c] = (hist_peak[c] >= cnt[c]) ? hist_peak[c] - cnt[c] : '0;
      hgt[c] = bar_scale(cnt[c], hist_peak[c]);
      top[c] = bar_scale(rest[c], hist_peak[c]);
    end
    o.rc = cnt[0][CNT_FLD_W-1:0];
    o.gc = cnt[1][CNT_FLD_W-1:0];
    o.bc = cnt[2][CNT_FLD_W-1:0];
    o.rh = hgt[0]; o.gh = hgt[1]; o.bh = hgt[2];
    o.rt = top[0]; o.gt = top[1]; o.bt = top[2];
    return o;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare each read item with the oldest pending readout
  always @(posedge clk_i) begin
    bar_readout_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (readouts_pending.size() == 0) begin
        mismatches++;
        $display("%0t unexpected read item: expected none actual count %0d",
                 $time, red_count_o);
      end else begin
        e = readouts_pending.pop_front();
        check_field("red_count", e.rc, red_count_o);
        check_field("green_count", e.gc, green_count_o);
        check_field("blue_count", e.bc, blue_count_o);
        check_field("red_height", e.rh, red_height_o);
        check_field("green_height", e.gh, green_height_o);
        check_field("blue_height", e.bh, blue_height_o);
        check_field("red_top", e.rt, red_top_o);
        check_field("green_top", e.gt, green_top_o);
        check_field("blue_top", e.bt, blue_top_o);
      end
    end
  end

  // Receiver: random stall stretches, one long hold-off on request
  initial begin
    bit held;
    int mode, span;
    held = 1'b0;
    forever begin
      if (long_hold_go && !held) begin
        held = 1'b1;
        @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (1500) @(posedge clk_i);
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Offer one item, hold it until taken, then update the mirror
  task automatic send_item(logic [1:0] cmd, logic [LVL_W-1:0] r, logic [LVL_W-1:0] g,
                           logic [LVL_W-1:0] b, logic [LVL_W-1:0] idx,
                           bit typed, bar_readout_t readout);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    red_level_i <= r;
    green_level_i <= g;
    blue_level_i <= b;
    bin_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    case (cmd)
      CMD_CLEAR: clear_histogram();
      CMD_ACCUM: count_pixel(r, g, b);
      CMD_READ:  readouts_pending.push_back(typed ? readout : predict_readout(idx));
      default: ;
    endcase
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 10);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (readouts_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_view(logic [VIEW_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    view_height = v;
    @(posedge clk_i);
  endtask

  function automatic logic [LVL_W-1:0] pick_level();
    if ($urandom_range(0, 9) < 6) return hot_level[$urandom_range(0, 7)];
    return LVL_W'($urandom);
  endfunction

  function automatic logic [1:0] pick_command();
    int p;
    p = $urandom_range(0, 99);
    if (p < 2) return CMD_CLEAR;
    if (p < 5) return CMD_UNUSED;
    if (p < 25) return CMD_READ;
    return CMD_ACCUM;
  endfunction

  initial begin
    stim_row_t rows [$];
    bar_readout_t none;
    logic [VIEW_W-1:0] views [5];
    logic [1:0] cmd;
    int n;

    none = '0;
    views = '{VIEW_W'(1), VIEW_W'(4095), VIEW_W'(0), VIEW_W'($urandom_range(2, 4094)),
              VIEW_RESET};
    // Directed rows; typed readouts only where obvious
    rows = '{
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, none},
      '{CMD_ACCUM,  8'h00, 8'hFF, 8'h80, 8'h00, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b1,
        '{rc:1, gc:0, bc:0, rh:128, gh:0, bh:0, rt:0, gt:128, bt:128}},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'h80, 1'b0, none},
      '{CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, none},
      '{CMD_ACCUM,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, none},
      '{CMD_ACCUM,  8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'h00, 1'b0, none},
      '{CMD_CLEAR,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, none},
      '{CMD_ACCUM,  8'h55, 8'hAA, 8'h0F, 8'h00, 1'b0, none},
      '{CMD_ACCUM,  8'h55, 8'hAA, 8'hF0, 8'h00, 1'b0, none},
      '{CMD_ACCUM,  8'h55, 8'h55, 8'hF0, 8'h00, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'h55, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'hAA, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'hF0, 1'b0, none},
      '{CMD_READ,   8'h00, 8'h00, 8'h00, 8'h0F, 1'b0, none}
    };

    clear_histogram();
    view_height = VIEW_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].r, rows[i].g, rows[i].b, rows[i].idx,
                rows[i].typed, rows[i].readout);

    // One random phase per view height setting
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_view(views[ph]);
      foreach (hot_level[k]) hot_level[k] = LVL_W'($urandom);
      if (ph == 1) begin
        long_hold_go = 1'b1;
        repeat (8) send_item(CMD_READ, '0, '0, '0, pick_level(), 1'b0, none);
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        cmd = pick_command();
        send_item(cmd, pick_level(), pick_level(), pick_level(), pick_level(),
                  1'b0, none);
        if (cmd != CMD_UNUSED) n++;
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
